// ===== hdl/priority_task_queue_core_assert.svh =====
// Assertion macros for the priority task queue.
// Both macros sample at the rising edge of clock.
// PTQ_ASSERT also skips every cycle in which reset is high.
// PTQ_ASSERT_ALWAYS keeps checking during reset.
`ifndef PRIORITY_TASK_QUEUE_CORE_ASSERT_SVH
`define PRIORITY_TASK_QUEUE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define PTQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define PTQ_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define PTQ_ASSERT(label, prop, msg)
`define PTQ_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== hdl/ptq_pkg.sv =====
package ptq_pkg;

   localparam int HANDLE_W = 32;
   localparam int PRIO_W   = 16;
   localparam int COPIES_W = 4;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 6;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_ELIG = 2'd2;

   localparam logic ACTION_PUSH = 1'b0;
   localparam logic ACTION_POP  = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_PUSH
   } state_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_POP
   } cell_op_type;

   // Broadcast to every cell of the chain.
   typedef struct packed {
      cell_op_type         op;
      logic [HANDLE_W-1:0] handle;
      logic [PRIO_W-1:0]   prio;
   } cell_ctrl_type;

endpackage

// ===== hdl/priority_task_queue_core.sv =====
// Channel   Ports                        Handshake
// request   req_action, req_task_handle, beat taken when start && !busy
//           req_priority_req, req_copies
// response  rsp_status, rsp_out_handle,  beat on the bus for one cycle while
//           rsp_out_priority,            rsp_valid is high; always taken
//           rsp_pushed_count, rsp_occupancy
//
// A pop's response shows in the cycle after the request beat and busy never
// rises. A push inserts one copy per cycle through the chain of cells and
// holds busy high while it inserts and while it reports (copies saturated
// to MAX_COPIES, fewer when the queue fills).
// Reset is synchronous and active high; it empties the queue (entry count to
// zero) with no clearing pass, since cell contents past the count are never
// read. The response side cannot stall; a new request beat is taken in the
// same cycle as a response.
`include "priority_task_queue_core_assert.svh"

module priority_task_queue_core #(
   parameter int QUEUE_DEPTH = 32,
   parameter int MAX_COPIES  = 15
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_action,
   input  logic [ptq_pkg::HANDLE_W-1:0]  req_task_handle,
   input  logic [ptq_pkg::PRIO_W-1:0]    req_priority_req,
   input  logic [ptq_pkg::COPIES_W-1:0]  req_copies,
   output logic                          rsp_valid,
   output logic [ptq_pkg::STATUS_W-1:0]  rsp_status,
   output logic [ptq_pkg::HANDLE_W-1:0]  rsp_out_handle,
   output logic [ptq_pkg::PRIO_W-1:0]    rsp_out_priority,
   output logic [ptq_pkg::COPIES_W-1:0]  rsp_pushed_count,
   output logic [ptq_pkg::OCC_W-1:0]     rsp_occupancy
);
   import ptq_pkg::*;

   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int COPY_MAX = (MAX_COPIES < (2**COPIES_W - 1)) ? MAX_COPIES
                                                               : (2**COPIES_W - 1);
   localparam logic [CNT_W-1:0]    FULL_COUNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [COPIES_W-1:0] COPY_SAT   = COPIES_W'(COPY_MAX);

   // Control state.
   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Push bookkeeping; no reset needed, loaded on every push beat.
   logic [HANDLE_W-1:0]  handle_ff, handle_in;
   logic [PRIO_W-1:0]    prio_ff, prio_in;
   logic [COPIES_W-1:0]  remain_ff, remain_in;
   logic [COPIES_W-1:0]  pushed_ff, pushed_in;

   // Response payload.
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [HANDLE_W-1:0]  out_handle_ff, out_handle_in;
   logic [PRIO_W-1:0]    out_prio_ff, out_prio_in;
   logic [COPIES_W-1:0]  out_pushed_ff, out_pushed_in;
   logic [CNT_W-1:0]     out_count_ff, out_count_in;

   logic                 accept;
   logic                 full;
   logic                 head_elig;
   cell_ctrl_type        ctrl;
   logic [COPIES_W-1:0]  copies_sat;
   logic [CNT_W+OCC_W-1:0] occ_ext;

   // Per-cell wiring of the chain.
   logic [QUEUE_DEPTH-1:0] cell_valid;
   logic [QUEUE_DEPTH-1:0] cell_keep;
   logic [HANDLE_W-1:0]    cell_handle [QUEUE_DEPTH];
   logic [PRIO_W-1:0]      cell_prio   [QUEUE_DEPTH];

   assign accept     = start && (state_ff == ST_IDLE);
   assign full       = (count_ff == FULL_COUNT);
   assign copies_sat = (req_copies > COPY_SAT) ? COPY_SAT : req_copies;
   // Head exists and is urgent enough for the pop bound.
   assign head_elig  = cell_valid[0] && (cell_prio[0] <= req_priority_req);

   // Cell chain: slot 0 is the head; valid comes from the entry count.
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic                left_keep;
      logic [HANDLE_W-1:0] left_handle;
      logic [PRIO_W-1:0]   left_prio;
      logic [HANDLE_W-1:0] right_handle;
      logic [PRIO_W-1:0]   right_prio;

      assign cell_valid[i] = (CNT_W'(i) < count_ff);

      if (i == 0) begin : g_head
         assign left_keep   = 1'b1;
         assign left_handle = ctrl.handle;
         assign left_prio   = ctrl.prio;
      end else begin : g_body
         assign left_keep   = cell_keep[i-1];
         assign left_handle = cell_handle[i-1];
         assign left_prio   = cell_prio[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         // Tail slot goes invalid on a pop; its contents do not matter.
         assign right_handle = ctrl.handle;
         assign right_prio   = ctrl.prio;
      end else begin : g_inner
         assign right_handle = cell_handle[i+1];
         assign right_prio   = cell_prio[i+1];
      end

      ptq_cell u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .valid        (cell_valid[i]),
         .left_keep    (left_keep),
         .left_handle  (left_handle),
         .left_prio    (left_prio),
         .right_handle (right_handle),
         .right_prio   (right_prio),
         .keep         (cell_keep[i]),
         .handle       (cell_handle[i]),
         .prio         (cell_prio[i])
      );
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_action == ACTION_PUSH)) state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if ((remain_ff == '0) || full) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath control and response.
   always_comb begin
      count_in      = count_ff;
      handle_in     = handle_ff;
      prio_in       = prio_ff;
      remain_in     = remain_ff;
      pushed_in     = pushed_ff;
      rsp_valid_in  = 1'b0;
      status_in     = status_ff;
      out_handle_in = out_handle_ff;
      out_prio_in   = out_prio_ff;
      out_pushed_in = out_pushed_ff;
      out_count_in  = out_count_ff;
      ctrl.op       = CELL_HOLD;
      ctrl.handle   = handle_ff;
      ctrl.prio     = prio_ff;
      busy          = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // Pop compares the head against the request bound.
            ctrl.prio = req_priority_req;
            if (accept) begin
               if (req_action == ACTION_PUSH) begin
                  handle_in = req_task_handle;
                  prio_in   = req_priority_req;
                  remain_in = copies_sat;
                  pushed_in = '0;
               end else begin
                  rsp_valid_in  = 1'b1;
                  out_pushed_in = '0;
                  if (head_elig) begin
                     ctrl.op       = CELL_POP;
                     count_in      = count_ff - 1'b1;
                     status_in     = STATUS_OK;
                     out_handle_in = cell_handle[0];
                     out_prio_in   = cell_prio[0];
                  end else begin
                     status_in     = STATUS_NOT_ELIG;
                     out_handle_in = '0;
                     out_prio_in   = '0;
                  end
                  out_count_in = count_in;
               end
            end
         end
         ST_PUSH: begin
            busy = 1'b1;
            if ((remain_ff == '0) || full) begin
               // Finish: report what went in.
               rsp_valid_in  = 1'b1;
               status_in     = (remain_ff == '0) ? STATUS_OK : STATUS_FULL;
               out_handle_in = '0;
               out_prio_in   = '0;
               out_pushed_in = pushed_ff;
               out_count_in  = count_ff;
            end else begin
               // Insert one copy per cycle; the chain shifts behind the slot.
               ctrl.op   = CELL_INSERT;
               count_in  = count_ff + 1'b1;
               remain_in = remain_ff - 1'b1;
               pushed_in = pushed_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      handle_ff     <= handle_in;
      prio_ff       <= prio_in;
      remain_ff     <= remain_in;
      pushed_ff     <= pushed_in;
      status_ff     <= status_in;
      out_handle_ff <= out_handle_in;
      out_prio_ff   <= out_prio_in;
      out_pushed_ff <= out_pushed_in;
      out_count_ff  <= out_count_in;
   end

   // Occupancy is the count masked or zero-extended to the field width.
   assign occ_ext = {{OCC_W{1'b0}}, out_count_ff};

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_handle   = out_handle_ff;
   assign rsp_out_priority = out_prio_ff;
   assign rsp_pushed_count = out_pushed_ff;
   assign rsp_occupancy    = occ_ext[OCC_W-1:0];

   `PTQ_ASSERT(a_count_bound, count_ff <= FULL_COUNT, "entry count beyond queue depth")
   `PTQ_ASSERT(a_rsp_has_cause, rsp_valid |-> $past(start || busy),
               "response beat without a request in flight")
   `PTQ_ASSERT(a_push_no_shrink, state_ff == ST_PUSH |=> count_ff >= $past(count_ff),
               "entry count dropped during a push")
   `PTQ_ASSERT(a_full_means_full, (rsp_valid && rsp_status == STATUS_FULL) |->
               (count_ff == FULL_COUNT), "full status with room left")
   `PTQ_ASSERT_ALWAYS(a_reset_idle, reset |=> (!busy && !rsp_valid),
               "block not idle after reset")

endmodule

// ===== hdl/ptq_cell.sv =====
module ptq_cell (
   input  logic                          clock,
   input  ptq_pkg::cell_ctrl_type        ctrl,
   input  logic                          valid,
   input  logic                          left_keep,
   input  logic [ptq_pkg::HANDLE_W-1:0]  left_handle,
   input  logic [ptq_pkg::PRIO_W-1:0]    left_prio,
   input  logic [ptq_pkg::HANDLE_W-1:0]  right_handle,
   input  logic [ptq_pkg::PRIO_W-1:0]    right_prio,
   output logic                          keep,
   output logic [ptq_pkg::HANDLE_W-1:0]  handle,
   output logic [ptq_pkg::PRIO_W-1:0]    prio
);
   import ptq_pkg::*;

   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic [PRIO_W-1:0]   prio_ff, prio_in;

   // Held entries at or ahead of the new priority stay put (FIFO on ties).
   assign keep = valid && (prio_ff <= ctrl.prio);

   always_comb begin
      handle_in = handle_ff;
      prio_in   = prio_ff;
      case (ctrl.op)
         CELL_INSERT: begin
            if (!keep) begin
               if (left_keep) begin
                  handle_in = ctrl.handle;
                  prio_in   = ctrl.prio;
               end else begin
                  handle_in = left_handle;
                  prio_in   = left_prio;
               end
            end
         end
         CELL_POP: begin
            handle_in = right_handle;
            prio_in   = right_prio;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      handle_ff <= handle_in;
      prio_ff   <= prio_in;
   end

   assign handle = handle_ff;
   assign prio   = prio_ff;

endmodule
